// ----- hw/rtl/assert_macros.svh -----
// ------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/cfgtok_pkg.sv -----
// ------------------------------------------------------------------------
// cfgtok_pkg
// Shared types and constants of the configuration text tokenizer.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfgtok_pkg;

    // Scanner states; error states carry their code
    typedef enum logic [3:0] {
        S_START    = 4'd0,
        S_COMM     = 4'd1,
        S_LINE     = 4'd2,
        S_MULTI    = 4'd3,
        S_MEND     = 4'd4,
        S_IDENT    = 4'd5,
        S_STR      = 4'd6,
        S_ESC      = 4'd7,
        S_HEX1     = 4'd8,
        S_HEX2     = 4'd9,
        S_ERR_CHAR = 4'd10,
        S_ERR_ESC  = 4'd11,
        S_ERR_HEX  = 4'd12
    } t_scan_state;

    typedef enum logic [1:0] {
        EV_TEXT  = 2'd0,
        EV_TOKEN = 2'd1,
        EV_ERROR = 2'd2,
        EV_END   = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_EQUALS = 3'd1,
        KIND_STRING = 3'd2,
        KIND_SB_OPEN  = 3'd3,
        KIND_SB_CLOSE = 3'd4,
        KIND_COMMA    = 3'd5,
        KIND_BR_OPEN  = 3'd6,
        KIND_BR_CLOSE = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ERR_CHAR = 2'd0,
        ERR_ESC  = 2'd1,
        ERR_HEX  = 2'd2,
        ERR_END  = 2'd3
    } t_err;

    // One result item as queued toward the output
    typedef struct packed {
        t_event      ev;
        t_kind       kind;
        logic [7:0]  data;
        t_err        err;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } t_result;

    // Up to two results caused by one character
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_scan_out;

    // Result queue depth
    localparam int RES_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SB_OPEN  = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SB_CLOSE = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_BR_OPEN  = 8'h7B;
    localparam logic [7:0] CH_BR_CLOSE = 8'h7D;

endpackage

// ----- hw/rtl/cfgtok_scan.sv -----
// ------------------------------------------------------------------------
// cfgtok_scan
// Lexer state machine with line/column counters; turns one character
// into zero, one or two results in the cycle it is accepted.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfgtok_scan #(
    parameter int POS_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_char,
    input  logic                  i_eoi,
    output cfgtok_pkg::t_scan_out o_scan
);
    import cfgtok_pkg::*;

    localparam int EXT_W = (POS_WIDTH > 16) ? POS_WIDTH : 16;

    // Token information before position is attached
    typedef struct packed {
        logic       has;
        t_event     ev;
        t_kind      kind;
        logic [7:0] data;
        t_err       err;
    } t_tok;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (is_digit(c))
            v = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = {1'b1, 4'(c[3:0] + 4'd9)};
        return v;
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_DASH || c == CH_UNDER;
    endfunction

    // Next state for a character seen in the start state
    function automatic t_scan_state start_next(input logic [7:0] c);
        t_scan_state s;
        case (c)
            CH_SPACE, CH_TAB, CH_CR, CH_LF,
            CH_EQUALS, CH_SB_OPEN, CH_SB_CLOSE,
            CH_COMMA, CH_BR_OPEN, CH_BR_CLOSE: s = S_START;
            CH_SLASH: s = S_COMM;
            CH_QUOTE: s = S_STR;
            default:  s = is_alpha(c) ? S_IDENT : S_ERR_CHAR;
        endcase
        return s;
    endfunction

    // Result for a character seen in the start state
    function automatic t_tok start_tok(input logic [7:0] c);
        t_tok t;
        t = '0;
        case (c)
            CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_SLASH, CH_QUOTE: t.has = 1'b0;
            CH_EQUALS:   begin t.has = 1'b1; t.ev = EV_TOKEN; t.kind = KIND_EQUALS; end
            CH_SB_OPEN:  begin t.has = 1'b1; t.ev = EV_TOKEN; t.kind = KIND_SB_OPEN; end
            CH_SB_CLOSE: begin t.has = 1'b1; t.ev = EV_TOKEN; t.kind = KIND_SB_CLOSE; end
            CH_COMMA:    begin t.has = 1'b1; t.ev = EV_TOKEN; t.kind = KIND_COMMA; end
            CH_BR_OPEN:  begin t.has = 1'b1; t.ev = EV_TOKEN; t.kind = KIND_BR_OPEN; end
            CH_BR_CLOSE: begin t.has = 1'b1; t.ev = EV_TOKEN; t.kind = KIND_BR_CLOSE; end
            default: begin
                t.has = 1'b1;
                if (is_alpha(c)) begin
                    t.ev   = EV_TEXT;
                    t.data = c;
                end else begin
                    t.ev  = EV_ERROR;
                    t.err = ERR_CHAR;
                end
            end
        endcase
        return t;
    endfunction

    t_scan_state            r_state, n_state;
    logic [3:0]             r_hex, n_hex;
    logic [POS_WIDTH-1:0]   r_line, n_line;
    logic [POS_WIDTH-1:0]   r_col, n_col;

    logic        w_err_state;
    logic [4:0]  w_hex;
    t_tok        w_start_tok;
    t_tok        w_tok0, w_tok1;
    logic [EXT_W-1:0] w_line_ext, w_col_ext;

    assign w_err_state = (r_state == S_ERR_CHAR) || (r_state == S_ERR_ESC)
                      || (r_state == S_ERR_HEX);
    assign w_hex       = hex_val(i_char);
    assign w_start_tok = start_tok(i_char);
    assign w_line_ext  = EXT_W'(r_line);
    assign w_col_ext   = EXT_W'(r_col);

    // Next state
    always_comb begin
        n_state = r_state;
        n_hex   = r_hex;
        if (i_eoi) begin
            n_state = S_START;
            n_hex   = '0;
        end else begin
            case (r_state)
                S_START: n_state = start_next(i_char);
                S_COMM: begin
                    if (i_char == CH_SLASH)     n_state = S_LINE;
                    else if (i_char == CH_STAR) n_state = S_MULTI;
                    else                        n_state = S_ERR_CHAR;
                end
                S_LINE:  if (i_char == CH_LF) n_state = S_START;
                S_MULTI: if (i_char == CH_STAR) n_state = S_MEND;
                S_MEND: begin
                    if (i_char == CH_SLASH)      n_state = S_START;
                    else if (i_char != CH_STAR)  n_state = S_MULTI;
                end
                S_IDENT: if (!is_ident(i_char)) n_state = start_next(i_char);
                S_STR: begin
                    if (i_char == CH_QUOTE)       n_state = S_START;
                    else if (i_char == CH_BSLASH) n_state = S_ESC;
                end
                S_ESC: begin
                    case (i_char)
                        CH_QUOTE, CH_BSLASH, CH_LOW_N, CH_LOW_T, CH_LOW_R, CH_ZERO:
                            n_state = S_STR;
                        CH_LOW_X: n_state = S_HEX1;
                        default:  n_state = S_ERR_ESC;
                    endcase
                end
                S_HEX1: begin
                    if (w_hex[4]) begin
                        n_state = S_HEX2;
                        n_hex   = w_hex[3:0];
                    end else begin
                        n_state = S_ERR_HEX;
                    end
                end
                S_HEX2:  n_state = w_hex[4] ? S_STR : S_ERR_HEX;
                S_ERR_CHAR, S_ERR_ESC, S_ERR_HEX: n_state = r_state;
                default: n_state = S_ERR_CHAR;
            endcase
        end
    end

    // Position counters; frozen while an error is held
    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (i_eoi) begin
            n_line = POS_WIDTH'(1);
            n_col  = POS_WIDTH'(1);
        end else if (!w_err_state) begin
            if (i_char == CH_LF) begin
                if (r_line != '1) n_line = r_line + POS_WIDTH'(1);
                n_col = POS_WIDTH'(1);
            end else if (r_col != '1) begin
                n_col = r_col + POS_WIDTH'(1);
            end
        end
    end

    // Results of the current character
    always_comb begin
        w_tok0 = '0;
        w_tok1 = '0;
        if (i_eoi) begin
            w_tok0.has = 1'b1;
            w_tok0.ev  = EV_ERROR;
            case (r_state)
                S_START:    w_tok0.ev  = EV_END;
                S_ERR_CHAR: w_tok0.err = ERR_CHAR;
                S_ERR_ESC:  w_tok0.err = ERR_ESC;
                S_ERR_HEX:  w_tok0.err = ERR_HEX;
                default:    w_tok0.err = ERR_END;
            endcase
        end else begin
            case (r_state)
                S_START: w_tok0 = w_start_tok;
                S_COMM: begin
                    if (i_char != CH_SLASH && i_char != CH_STAR) begin
                        w_tok0.has = 1'b1;
                        w_tok0.ev  = EV_ERROR;
                        w_tok0.err = ERR_CHAR;
                    end
                end
                S_IDENT: begin
                    w_tok0.has = 1'b1;
                    if (is_ident(i_char)) begin
                        w_tok0.ev   = EV_TEXT;
                        w_tok0.data = i_char;
                    end else begin
                        // identifier closes, terminator rescanned from start
                        w_tok0.ev   = EV_TOKEN;
                        w_tok0.kind = KIND_IDENT;
                        w_tok1      = w_start_tok;
                    end
                end
                S_STR: begin
                    if (i_char == CH_QUOTE) begin
                        w_tok0.has  = 1'b1;
                        w_tok0.ev   = EV_TOKEN;
                        w_tok0.kind = KIND_STRING;
                    end else if (i_char != CH_BSLASH) begin
                        w_tok0.has  = 1'b1;
                        w_tok0.ev   = EV_TEXT;
                        w_tok0.data = i_char;
                    end
                end
                S_ESC: begin
                    w_tok0.has = 1'b1;
                    w_tok0.ev  = EV_TEXT;
                    case (i_char)
                        CH_QUOTE:  w_tok0.data = CH_QUOTE;
                        CH_BSLASH: w_tok0.data = CH_BSLASH;
                        CH_LOW_N:  w_tok0.data = CH_LF;
                        CH_LOW_T:  w_tok0.data = CH_TAB;
                        CH_LOW_R:  w_tok0.data = CH_CR;
                        CH_ZERO:   w_tok0.data = '0;
                        CH_LOW_X:  w_tok0.has  = 1'b0;
                        default: begin
                            w_tok0.ev  = EV_ERROR;
                            w_tok0.err = ERR_ESC;
                        end
                    endcase
                end
                S_HEX1: begin
                    if (!w_hex[4]) begin
                        w_tok0.has = 1'b1;
                        w_tok0.ev  = EV_ERROR;
                        w_tok0.err = ERR_HEX;
                    end
                end
                S_HEX2: begin
                    w_tok0.has = 1'b1;
                    if (w_hex[4]) begin
                        w_tok0.ev   = EV_TEXT;
                        w_tok0.data = {r_hex, w_hex[3:0]};
                    end else begin
                        w_tok0.ev  = EV_ERROR;
                        w_tok0.err = ERR_HEX;
                    end
                end
                default: w_tok0 = '0;
            endcase
        end
    end

    // Pack results with position and run marker
    always_comb begin
        o_scan = '0;
        o_scan.r0.ev   = w_tok0.ev;
        o_scan.r0.kind = w_tok0.kind;
        o_scan.r0.data = w_tok0.data;
        o_scan.r0.err  = w_tok0.err;
        o_scan.r0.line = w_line_ext[15:0];
        o_scan.r0.col  = w_col_ext[15:0];
        o_scan.r1.ev   = w_tok1.ev;
        o_scan.r1.kind = w_tok1.kind;
        o_scan.r1.data = w_tok1.data;
        o_scan.r1.err  = w_tok1.err;
        o_scan.r1.line = w_line_ext[15:0];
        o_scan.r1.col  = w_col_ext[15:0];
        o_scan.r1.last = 1'b1;
        if (i_accept) begin
            if (w_tok1.has) begin
                o_scan.count = 2'd2;
            end else if (w_tok0.has) begin
                o_scan.count   = 2'd1;
                o_scan.r0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_START;
            r_hex   <= '0;
            r_line  <= POS_WIDTH'(1);
            r_col   <= POS_WIDTH'(1);
        end else if (i_accept) begin
            r_state <= n_state;
            r_hex   <= n_hex;
            r_line  <= n_line;
            r_col   <= n_col;
        end
    end

    // A held error stays silent until end of input
    `ASSERT_IMPLY(a_err_silent, i_clk, i_rst_n, i_accept && !i_eoi && w_err_state,
        o_scan.count == 2'd0, "result produced in error state")
    // Two results only when an identifier closes
    `ASSERT_IMPLY(a_two_from_ident, i_clk, i_rst_n, o_scan.count == 2'd2,
        r_state == S_IDENT && !i_eoi, "two results outside identifier")
    // End of input always yields exactly one result and returns to start
    `ASSERT_NEXT(a_end_resets, i_clk, i_rst_n, i_accept && i_eoi,
        r_state == S_START && r_line == POS_WIDTH'(1), "end did not reset scanner")

endmodule

// ----- hw/rtl/cfgtok_queue.sv -----
// ------------------------------------------------------------------------
// cfgtok_queue
// Result queue: takes up to two results per cycle, hands out one on pop.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfgtok_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cfgtok_pkg::t_scan_out i_push,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_room_low,
    output cfgtok_pkg::t_result   o_head
);
    import cfgtok_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    t_result            r_mem [RES_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_pop;

    assign w_pop      = i_pop && (r_count != '0);
    assign o_valid    = (r_count != '0);
    assign o_room_low = (r_count > CNT_W'(RES_DEPTH - 2));
    assign o_head     = r_mem[r_rptr];

    // Pointer and level update
    always_comb begin
        n_wptr  = r_wptr + PTR_W'(i_push.count);
        n_rptr  = r_rptr + PTR_W'(w_pop);
        n_count = r_count + CNT_W'(i_push.count) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage writes; second result lands right behind the first
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wptr] <= i_push.r0;
        if (i_push.count == 2'd2) r_mem[PTR_W'(r_wptr + PTR_W'(1))] <= i_push.r1;
    end

    `ASSERT_ALWAYS(a_level_bound, i_clk, i_rst_n, r_count <= CNT_W'(RES_DEPTH),
        "queue level above depth")
    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n,
        (CNT_W+1)'(r_count) + (CNT_W+1)'(i_push.count) <= (CNT_W+1)'(RES_DEPTH),
        "push into full queue")
    `ASSERT_IMPLY(a_ptr_gap, i_clk, i_rst_n, r_count != CNT_W'(RES_DEPTH),
        PTR_W'(r_wptr - r_rptr) == PTR_W'(r_count), "pointers disagree with level")

endmodule

// ----- hw/rtl/config_text_tokenizer.sv -----
// ------------------------------------------------------------------------
// config_text_tokenizer
// Streaming lexer for configuration text, one character per transfer.
// ------------------------------------------------------------------------
// Results are registered in the queue before being offered. Throughput:
// one character per cycle when not stalled; a character closing an identifier
// yields two results, which leave at one per cycle when not stalled, from a
// four-entry result queue that stalls the input when under two slots.
// Reset (synchronous): scanner to start, line and column to one, queue empty.
`timescale 1ns / 1ps

module config_text_tokenizer #(
    parameter int POS_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_char,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_res,
    output logic [2:0]  o_token_kind,
    output logic [7:0]  o_text_byte,
    output logic [1:0]  o_error_code,
    output logic [15:0] o_line_no,
    output logic [15:0] o_col_no,
    output logic        o_last_of_run
);
    import cfgtok_pkg::*;

    logic      w_accept;
    logic      w_room_low;
    t_scan_out w_scan;
    t_result   w_head;

    assign o_in_stall = w_room_low;
    assign w_accept   = i_in_valid && !w_room_low;

    // Lexer state machine
    cfgtok_scan #(
        .POS_WIDTH (POS_WIDTH)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_char   (i_in_char),
        .i_eoi    (i_end_of_input),
        .o_scan   (w_scan)
    );

    // Result queue
    cfgtok_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_scan),
        .i_pop      (!i_out_stall),
        .o_valid    (o_out_valid),
        .o_room_low (w_room_low),
        .o_head     (w_head)
    );

    // Output fields
    assign o_event_res   = w_head.ev;
    assign o_token_kind  = w_head.kind;
    assign o_text_byte   = w_head.data;
    assign o_error_code  = w_head.err;
    assign o_line_no     = w_head.line;
    assign o_col_no      = w_head.col;
    assign o_last_of_run = w_head.last;

endmodule
